// File: design/dpa_pkg.sv
// Shared types, codes and helpers of the dynamic partition allocator.
package dpa_pkg;

  localparam int unsigned DPA_SLOTS = 8;
  localparam int unsigned ID_W      = 31;
  localparam int unsigned SZ_W      = 16;
  localparam int unsigned OFS_W     = 20;
  localparam int unsigned SUM_W     = OFS_W + 1;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned IN_DW     = 80;
  localparam int unsigned IN_UW     = 2;
  localparam int unsigned OUT_DW    = 112;
  localparam int unsigned OUT_UW    = 3;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 16;

  localparam logic [SZ_W-1:0]  STORE_RST   = 16'd2048;
  localparam logic [SZ_W-1:0]  MINP_RST    = 16'd32;
  localparam logic [CNT_W-1:0] COMPACT_RST = 8'd1;

  localparam logic [CFG_AW-1:0] CFG_FIT     = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_VICTIM  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_STORE   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_MINP    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_COMPACT = 3'd4;

  localparam logic [IN_UW-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [IN_UW-1:0] REQ_TOUCH  = 2'd1;
  localparam logic [IN_UW-1:0] REQ_LOOKUP = 2'd2;

  localparam logic [OUT_UW-1:0] K_EVICTED = 3'd0;
  localparam logic [OUT_UW-1:0] K_MOVE    = 3'd1;
  localparam logic [OUT_UW-1:0] K_PLACED  = 3'd2;
  localparam logic [OUT_UW-1:0] K_FAILED  = 3'd3;
  localparam logic [OUT_UW-1:0] K_HIT     = 3'd4;
  localparam logic [OUT_UW-1:0] K_MISS    = 3'd5;
  localparam logic [OUT_UW-1:0] K_TOUCHED = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_QUERY,
    OP_FAIL,
    OP_SCAN_INIT,
    OP_HOLE_STEP,
    OP_VICT_STEP,
    OP_RELEASE,
    OP_ADJ_STEP,
    OP_MERGE_STEP,
    OP_COMP_INIT,
    OP_COMP_STEP,
    OP_COMP_END,
    OP_PLACE
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [IN_UW-1:0] req_type;
    logic             free_item;
    logic             first_fit;
    logic             hole_hit;
    logic             hole_found;
    logic             victim_found;
    logic             free_hole;
    logic             adj_hit;
    logic             merge_hit;
    logic             compact_due;
    logic             comp_emit;
    logic             emit_ok;
  } stat_t;

  function automatic logic [SZ_W-1:0] occ(input logic [SZ_W-1:0] bytes,
                                          input logic [SZ_W-1:0] minp);
    logic [SZ_W-1:0] m;
    m = (bytes > minp) ? bytes : minp;
    return (m == '0) ? SZ_W'(1) : m;
  endfunction

endpackage

// File: design/dpa_ctrl.sv
// Request sequencer of the dynamic partition allocator.
module dpa_ctrl #(
  parameter int unsigned TABLE_SLOTS = dpa_pkg::DPA_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  dpa_pkg::stat_t                 st,
  output dpa_pkg::cmd_t                  cmd,
  output logic [$clog2(TABLE_SLOTS)-1:0] cmd_idx
);
  import dpa_pkg::*;

  localparam int unsigned SW = $clog2(TABLE_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_QUERY, S_FAIL, S_HOLE, S_HOLE_END, S_VICT, S_VICT_END,
    S_REL, S_ADJ, S_MERGE, S_CHK, S_COMP, S_COMP_END, S_PLACE
  } state_t;

  state_t          state_r, state_nxt;
  logic [SW-1:0]   idx_r, idx_nxt;
  logic            last;

  assign cmd_idx = idx_r;
  assign last    = (idx_r == SW'(TABLE_SLOTS - 1));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.req_type)
          REQ_ALLOC: begin
            if (st.free_item) begin
              cmd.op    = OP_SCAN_INIT;
              idx_nxt   = '0;
              state_nxt = S_HOLE;
            end else begin
              state_nxt = S_FAIL;
            end
          end
          REQ_TOUCH, REQ_LOOKUP: state_nxt = S_QUERY;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_QUERY: begin
        if (st.emit_ok) begin
          cmd.op    = OP_QUERY;
          state_nxt = S_IDLE;
        end
      end
      S_FAIL: begin
        if (st.emit_ok) begin
          cmd.op    = OP_FAIL;
          state_nxt = S_IDLE;
        end
      end
      S_HOLE: begin
        cmd.op = OP_HOLE_STEP;
        if (st.first_fit && st.hole_hit) begin
          state_nxt = S_PLACE;
        end else if (last) begin
          state_nxt = S_HOLE_END;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      S_HOLE_END: begin
        if (st.hole_found) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          idx_nxt   = '0;
          state_nxt = S_VICT;
        end
      end
      S_VICT: begin
        cmd.op = OP_VICT_STEP;
        if (last) begin
          state_nxt = S_VICT_END;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      S_VICT_END: state_nxt = st.victim_found ? S_REL : S_FAIL;
      S_REL: begin
        if (st.emit_ok) begin
          cmd.op    = OP_RELEASE;
          idx_nxt   = '0;
          state_nxt = st.free_hole ? S_MERGE : S_ADJ;
        end
      end
      S_ADJ: begin
        cmd.op = OP_ADJ_STEP;
        if (st.adj_hit) begin
          idx_nxt   = '0;
          state_nxt = S_MERGE;
        end else if (last) begin
          state_nxt = S_CHK;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      S_MERGE: begin
        cmd.op = OP_MERGE_STEP;
        if (st.merge_hit) begin
          idx_nxt = '0;
        end else if (last) begin
          state_nxt = S_CHK;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      S_CHK: begin
        idx_nxt = '0;
        if (st.compact_due) begin
          cmd.op    = OP_COMP_INIT;
          state_nxt = S_COMP;
        end else begin
          cmd.op    = OP_SCAN_INIT;
          state_nxt = S_HOLE;
        end
      end
      S_COMP: begin
        if (!st.comp_emit || st.emit_ok) begin
          cmd.op = OP_COMP_STEP;
          if (last) begin
            state_nxt = S_COMP_END;
          end else begin
            idx_nxt = idx_r + SW'(1);
          end
        end
      end
      S_COMP_END: begin
        cmd.op    = OP_COMP_END;
        idx_nxt   = '0;
        state_nxt = S_HOLE;
      end
      S_PLACE: begin
        if (st.emit_ok) begin
          cmd.op    = OP_PLACE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_emit_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_QUERY || cmd.op == OP_FAIL || cmd.op == OP_RELEASE ||
     cmd.op == OP_PLACE || (cmd.op == OP_COMP_STEP && st.comp_emit)) |-> st.emit_ok)
    else $error("result issued while output register blocked");

endmodule

// File: design/dpa_dp.sv
// Item and hole tables, scan registers and result register of the allocator.
module dpa_dp #(
  parameter int unsigned TABLE_SLOTS = dpa_pkg::DPA_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpa_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [dpa_pkg::CFG_DW-1:0]     cfg_wdata,
  input  logic [dpa_pkg::IN_DW-1:0]      in_tdata,
  input  logic [dpa_pkg::IN_UW-1:0]      in_tuser,
  input  dpa_pkg::cmd_t                  cmd,
  input  logic [$clog2(TABLE_SLOTS)-1:0] cmd_idx,
  output dpa_pkg::stat_t                 st,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dpa_pkg::OUT_DW-1:0]     out_tdata,
  output logic [dpa_pkg::OUT_UW-1:0]     out_tuser,
  output logic                           out_tlast
);
  import dpa_pkg::*;

  localparam int unsigned SW = $clog2(TABLE_SLOTS);
  localparam int unsigned KW = $clog2(TABLE_SLOTS + 1);

  logic              fit_r, vict_r;
  logic [SZ_W-1:0]   store_r, minp_r;
  logic [CNT_W-1:0]  ce_r, fsc_r;
  logic [STAMP_W-1:0] age_r;

  logic [TABLE_SLOTS-1:0] iv_r, hv_r;
  logic [ID_W-1:0]    iid_r   [TABLE_SLOTS];
  logic [ID_W-1:0]    icor_r  [TABLE_SLOTS];
  logic [OFS_W-1:0]   ioff_r  [TABLE_SLOTS];
  logic [SZ_W-1:0]    ibytes_r[TABLE_SLOTS];
  logic [STAMP_W-1:0] iborn_r [TABLE_SLOTS];
  logic [STAMP_W-1:0] iused_r [TABLE_SLOTS];
  logic [OFS_W-1:0]   hoff_r  [TABLE_SLOTS];
  logic [OFS_W-1:0]   hb_r    [TABLE_SLOTS];

  logic [IN_UW-1:0]  rtype_r;
  logic [ID_W-1:0]   rid_r, rcor_r;
  logic [SZ_W-1:0]   rsize_r, need_r;
  logic              hfound_r, vfound_r;
  logic [SW-1:0]     best_r, v_r, h_r;
  logic [OFS_W-1:0]  bestb_r;
  logic [STAMP_W-1:0] vage_r;
  logic [OFS_W-1:0]  ro_r;
  logic [SZ_W-1:0]   rsz_r;
  logic [OFS_W-1:0]  pos_r;
  logic [KW-1:0]     k_r;

  logic [ID_W-1:0]   o_id_r, o_cor_r;
  logic [SZ_W-1:0]   o_off_r, o_noff_r, o_size_r;
  logic [OUT_UW-1:0] o_kind_r;
  logic              o_last_r, o_valid_r;

  logic [SW-1:0]     fs, fh, fi, lo, hi;
  logic              fs_ok, fh_ok, fi_ok;
  logic [STAMP_W-1:0] age_c;
  logic [SZ_W-1:0]   occ_i, occ_v;
  logic              adj1, adj2, hole_hit, merge_hit, comp_emit, emit_ok;
  logic [OFS_W-1:0]  hb_left;
  logic              clr;
  logic [SZ_W-1:0]   clr_bytes;

  logic              e_en, e_last;
  logic [OUT_UW-1:0] e_kind;
  logic [ID_W-1:0]   e_id, e_cor;
  logic [SZ_W-1:0]   e_off, e_noff, e_size;

  always_comb begin
    fs = '0; fs_ok = 1'b0; fh = '0; fh_ok = 1'b0; fi = '0; fi_ok = 1'b0;
    for (int j = 0; j < TABLE_SLOTS; j++) begin
      if (!iv_r[j] && !fs_ok) begin
        fs = SW'(j); fs_ok = 1'b1;
      end
      if (!hv_r[j] && !fh_ok) begin
        fh = SW'(j); fh_ok = 1'b1;
      end
      if (iv_r[j] && iid_r[j] == rid_r && !fi_ok) begin
        fi = SW'(j); fi_ok = 1'b1;
      end
    end
  end

  assign occ_i     = occ(ibytes_r[cmd_idx], minp_r);
  assign occ_v     = occ(ibytes_r[v_r], minp_r);
  assign age_c     = age_r - (vict_r ? iused_r[cmd_idx] : iborn_r[cmd_idx]);
  assign hole_hit  = hv_r[cmd_idx] && (hb_r[cmd_idx] >= OFS_W'(need_r));
  assign adj1      = (SUM_W'(hoff_r[cmd_idx]) + SUM_W'(hb_r[cmd_idx])) == SUM_W'(ro_r);
  assign adj2      = SUM_W'(hoff_r[cmd_idx]) == (SUM_W'(ro_r) + SUM_W'(rsz_r));
  assign merge_hit = (cmd_idx != h_r) && hv_r[cmd_idx] &&
                     ((SUM_W'(hoff_r[cmd_idx]) ==
                       SUM_W'(hoff_r[h_r]) + SUM_W'(hb_r[h_r])) ||
                      (SUM_W'(hoff_r[cmd_idx]) + SUM_W'(hb_r[cmd_idx]) ==
                       SUM_W'(hoff_r[h_r])));
  assign lo        = (cmd_idx < h_r) ? cmd_idx : h_r;
  assign hi        = (cmd_idx < h_r) ? h_r : cmd_idx;
  assign comp_emit = iv_r[cmd_idx] && (ioff_r[cmd_idx] != pos_r);
  assign emit_ok   = !o_valid_r || out_tready;
  assign hb_left   = hb_r[best_r] - OFS_W'(need_r);

  assign clr       = cfg_we && (cfg_addr == CFG_STORE || cfg_addr == CFG_MINP);
  assign clr_bytes = (cfg_addr == CFG_STORE) ? cfg_wdata : store_r;

  always_comb begin
    st.req_type     = rtype_r;
    st.free_item    = fs_ok;
    st.first_fit    = !fit_r;
    st.hole_hit     = hole_hit;
    st.hole_found   = hfound_r;
    st.victim_found = vfound_r;
    st.free_hole    = fh_ok;
    st.adj_hit      = adj1 || adj2;
    st.merge_hit    = merge_hit;
    st.compact_due  = (ce_r <= CNT_W'(1)) || (fsc_r >= ce_r);
    st.comp_emit    = comp_emit;
    st.emit_ok      = emit_ok;
  end

  always_comb begin
    e_en = 1'b0; e_last = 1'b0; e_kind = K_FAILED; e_id = rid_r; e_cor = '0;
    e_off = '0; e_noff = '0; e_size = '0;
    case (cmd.op)
      OP_QUERY: begin
        e_en = 1'b1; e_last = 1'b1;
        if (!fi_ok) begin
          e_kind = K_MISS;
        end else if (rtype_r == REQ_TOUCH) begin
          e_kind = K_TOUCHED;
        end else begin
          e_kind = K_HIT;
          e_off  = ioff_r[fi][SZ_W-1:0];
          e_size = ibytes_r[fi];
          e_cor  = icor_r[fi];
        end
      end
      OP_FAIL: begin
        e_en = 1'b1; e_last = 1'b1;
      end
      OP_RELEASE: begin
        e_en = 1'b1; e_kind = K_EVICTED; e_id = iid_r[v_r];
      end
      OP_COMP_STEP: begin
        e_en   = comp_emit;
        e_kind = K_MOVE;
        e_id   = iid_r[cmd_idx];
        e_off  = ioff_r[cmd_idx][SZ_W-1:0];
        e_noff = pos_r[SZ_W-1:0];
        e_size = ibytes_r[cmd_idx];
      end
      OP_PLACE: begin
        e_en = 1'b1; e_last = 1'b1;
        if (fs_ok) begin
          e_kind = K_PLACED;
          e_off  = hoff_r[best_r][SZ_W-1:0];
        end
      end
      default: e_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r     <= 1'b0;
      vict_r    <= 1'b0;
      store_r   <= STORE_RST;
      minp_r    <= MINP_RST;
      ce_r      <= COMPACT_RST;
      fsc_r     <= '0;
      age_r     <= '0;
      iv_r      <= '0;
      hv_r      <= TABLE_SLOTS'(1);
      for (int j = 0; j < TABLE_SLOTS; j++) begin
        hoff_r[j] <= '0;
        hb_r[j]   <= '0;
      end
      hb_r[0]   <= OFS_W'(STORE_RST);
      hfound_r  <= 1'b0;
      vfound_r  <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (e_en) begin
        o_valid_r <= 1'b1;
        o_kind_r  <= e_kind;
        o_id_r    <= e_id;
        o_off_r   <= e_off;
        o_noff_r  <= e_noff;
        o_size_r  <= e_size;
        o_cor_r   <= e_cor;
        o_last_r  <= e_last;
      end else if (out_tready) begin
        o_valid_r <= 1'b0;
      end

      case (cmd.op)
        OP_ACCEPT: begin
          rtype_r <= in_tuser;
          rid_r   <= in_tdata[ID_W-1:0];
          rsize_r <= in_tdata[ID_W+SZ_W-1:ID_W];
          rcor_r  <= in_tdata[2*ID_W+SZ_W-1:ID_W+SZ_W];
          need_r  <= occ(in_tdata[ID_W+SZ_W-1:ID_W], minp_r);
        end
        OP_QUERY: begin
          if (fi_ok && rtype_r == REQ_TOUCH) begin
            age_r      <= age_r + STAMP_W'(1);
            iused_r[fi] <= age_r + STAMP_W'(1);
          end
        end
        OP_SCAN_INIT: begin
          hfound_r <= 1'b0;
          vfound_r <= 1'b0;
        end
        OP_HOLE_STEP: begin
          if (hole_hit && (!hfound_r || (fit_r && hb_r[cmd_idx] < bestb_r))) begin
            hfound_r <= 1'b1;
            best_r   <= cmd_idx;
            bestb_r  <= hb_r[cmd_idx];
          end
        end
        OP_VICT_STEP: begin
          if (iv_r[cmd_idx] && (!vfound_r || age_c > vage_r)) begin
            vfound_r <= 1'b1;
            v_r      <= cmd_idx;
            vage_r   <= age_c;
          end
        end
        OP_RELEASE: begin
          iv_r[v_r] <= 1'b0;
          if (fsc_r != '1) begin
            fsc_r <= fsc_r + CNT_W'(1);
          end
          ro_r  <= ioff_r[v_r];
          rsz_r <= occ_v;
          if (fh_ok) begin
            hv_r[fh]   <= 1'b1;
            hoff_r[fh] <= ioff_r[v_r];
            hb_r[fh]   <= OFS_W'(occ_v);
            h_r        <= fh;
          end
        end
        OP_ADJ_STEP: begin
          if (adj1) begin
            hb_r[cmd_idx] <= hb_r[cmd_idx] + OFS_W'(rsz_r);
            h_r           <= cmd_idx;
          end else if (adj2) begin
            hoff_r[cmd_idx] <= ro_r;
            hb_r[cmd_idx]   <= hb_r[cmd_idx] + OFS_W'(rsz_r);
            h_r             <= cmd_idx;
          end
        end
        OP_MERGE_STEP: begin
          if (merge_hit) begin
            hv_r[hi]   <= 1'b0;
            hoff_r[hi] <= '0;
            hb_r[hi]   <= '0;
            hoff_r[lo] <= (hoff_r[cmd_idx] < hoff_r[h_r]) ? hoff_r[cmd_idx] : hoff_r[h_r];
            hb_r[lo]   <= hb_r[cmd_idx] + hb_r[h_r];
            h_r        <= lo;
          end
        end
        OP_COMP_INIT: begin
          pos_r <= '0;
          k_r   <= '0;
        end
        OP_COMP_STEP: begin
          if (iv_r[cmd_idx]) begin
            iid_r[k_r[SW-1:0]]    <= iid_r[cmd_idx];
            icor_r[k_r[SW-1:0]]   <= icor_r[cmd_idx];
            ibytes_r[k_r[SW-1:0]] <= ibytes_r[cmd_idx];
            iborn_r[k_r[SW-1:0]]  <= iborn_r[cmd_idx];
            iused_r[k_r[SW-1:0]]  <= iused_r[cmd_idx];
            ioff_r[k_r[SW-1:0]]   <= OFS_W'(pos_r[SZ_W-1:0]);
            iv_r[k_r[SW-1:0]]     <= 1'b1;
            pos_r                 <= pos_r + OFS_W'(occ_i);
            k_r                   <= k_r + KW'(1);
          end
        end
        OP_COMP_END: begin
          for (int j = 0; j < TABLE_SLOTS; j++) begin
            if (KW'(j) >= k_r) begin
              iv_r[j] <= 1'b0;
            end
            hoff_r[j] <= '0;
            hb_r[j]   <= '0;
          end
          hv_r <= '0;
          if (pos_r < OFS_W'(store_r)) begin
            hv_r[0]   <= 1'b1;
            hoff_r[0] <= pos_r;
            hb_r[0]   <= OFS_W'(store_r) - pos_r;
          end
          fsc_r    <= '0;
          hfound_r <= 1'b0;
          vfound_r <= 1'b0;
        end
        OP_PLACE: begin
          if (fs_ok) begin
            age_r        <= age_r + STAMP_W'(1);
            iv_r[fs]     <= 1'b1;
            iid_r[fs]    <= rid_r;
            icor_r[fs]   <= rcor_r;
            ioff_r[fs]   <= hoff_r[best_r];
            ibytes_r[fs] <= rsize_r;
            iborn_r[fs]  <= age_r + STAMP_W'(1);
            iused_r[fs]  <= age_r + STAMP_W'(1);
            hb_r[best_r] <= hb_left;
            if (hb_left == '0) begin
              hv_r[best_r]   <= 1'b0;
              hoff_r[best_r] <= '0;
            end else begin
              hoff_r[best_r] <= hoff_r[best_r] + OFS_W'(need_r);
            end
          end
        end
        default: ;
      endcase

      if (cfg_we) begin
        case (cfg_addr)
          CFG_FIT:     fit_r   <= cfg_wdata[0];
          CFG_VICTIM:  vict_r  <= cfg_wdata[0];
          CFG_STORE:   store_r <= cfg_wdata;
          CFG_MINP:    minp_r  <= cfg_wdata;
          CFG_COMPACT: ce_r    <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
      if (clr) begin
        iv_r <= '0;
        hv_r <= '0;
        for (int j = 0; j < TABLE_SLOTS; j++) begin
          hoff_r[j] <= '0;
          hb_r[j]   <= '0;
        end
        hb_r[0] <= OFS_W'(clr_bytes);
        hv_r[0] <= (clr_bytes != '0);
        fsc_r   <= '0;
      end
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, o_cor_r, o_size_r, o_noff_r, o_off_r, o_id_r};

  a_compact_one_hole: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_COMP_END) |=> (hv_r[TABLE_SLOTS-1:1] == '0))
    else $error("more than one hole left after compaction");

  a_place_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_PLACE && fs_ok) |=> (age_r == $past(age_r) + STAMP_W'(1)))
    else $error("age stamp not advanced on placement");

endmodule

// File: design/dynamic_partition_allocator.sv
// Top level of the dynamic partition allocator: sequencer plus tables.
// Requests enter on the in_ stream (tuser = request type, tdata = item id,
// size, correlative id); results leave on the out_ stream, one or more for
// a known request type, tlast marking the final one. Configuration registers
// are written through cfg_we / cfg_addr / cfg_wdata while no request is in
// progress; writing the store size or minimum partition empties the store.
// One request is handled at a time. A touch or lookup passes the dispatch
// and query states before its result is registered, and the next request
// is taken once the sequencer is back in idle. An allocate without eviction
// scans the N table slots for a hole, first fit stopping at the first that
// fits, and then places the item. Each eviction adds a victim scan, hole
// merging, compaction when due and a fresh hole scan.
// Results sit in one output register: while the receiver stalls, the
// sequencer holds at the next result and takes no new request.
// After reset the store is one hole of 2048 bytes, no items are held and
// the first request is taken in the next cycle.
module dynamic_partition_allocator #(
  parameter int unsigned TABLE_SLOTS = dpa_pkg::DPA_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dpa_pkg::IN_DW-1:0]  in_tdata,   // item_id, item_size, correl_id
  input  logic [dpa_pkg::IN_UW-1:0]  in_tuser,   // req_type
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dpa_pkg::OUT_DW-1:0] out_tdata,  // out_id, offset, new_offset, out_size, out_correl
  output logic [dpa_pkg::OUT_UW-1:0] out_tuser,  // kind
  output logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [dpa_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [dpa_pkg::CFG_DW-1:0] cfg_wdata
);
  import dpa_pkg::*;

  cmd_t                           cmd;
  stat_t                          st;
  logic [$clog2(TABLE_SLOTS)-1:0] cmd_idx;

  dpa_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd),
    .cmd_idx   (cmd_idx)
  );

  dpa_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .cmd_idx    (cmd_idx),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/sv/dynamic_partition_allocator_tb.sv
// Testbench for the dynamic partition allocator: requests checked against a predictor.
`timescale 1ns / 1ps

module dynamic_partition_allocator_tb;
  import dpa_pkg::*;

  localparam int SLOTS = 8;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [1:0]  req;
    logic [30:0] id;
    logic [15:0] size;
    logic [30:0] cor;
  } request_t;

  typedef struct {
    logic [2:0]  kind;
    logic [30:0] id;
    logic [15:0] off;
    logic [15:0] noff;
    logic [15:0] size;
    logic [30:0] cor;
    logic        last;
  } outcome_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [IN_DW-1:0] in_tdata;
  logic [IN_UW-1:0] in_tuser;
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_DW-1:0] out_tdata;
  logic [OUT_UW-1:0] out_tuser;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  dynamic_partition_allocator dut (.*);

  request_t pending_q[$];
  request_t cur_req;
  outcome_t expected_q[$];
  int errors = 0;
  int cycles = 0;

  // allocator shadow state
  int unsigned fit_pol, victim_pol, store_sz, min_part, compact_n;
  bit          it_valid[SLOTS];
  int unsigned it_id[SLOTS], it_cor[SLOTS], it_off[SLOTS], it_bytes[SLOTS];
  int unsigned it_born[SLOTS], it_used[SLOTS];
  bit          ho_valid[SLOTS];
  int unsigned ho_off[SLOTS], ho_bytes[SLOTS];
  int unsigned frees, stamp;

  function automatic int unsigned occ_bytes(int unsigned b);
    int unsigned m;
    m = b > min_part ? b : min_part;
    return m == 0 ? 1 : m;
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < SLOTS; i++) begin
      it_valid[i] = 0;
      ho_valid[i] = 0;
      ho_off[i] = 0;
      ho_bytes[i] = 0;
    end
    ho_bytes[0] = store_sz;
    ho_valid[0] = store_sz != 0;
    frees = 0;
  endfunction

  function automatic void put(logic [2:0] k, int unsigned id, int unsigned off,
                              int unsigned noff, int unsigned sz, int unsigned cor);
    outcome_t r;
    r.kind = k;
    r.id = id[30:0];
    r.off = off[15:0];
    r.noff = noff[15:0];
    r.size = sz[15:0];
    r.cor = cor[30:0];
    r.last = 0;
    expected_q.push_back(r);
  endfunction

  function automatic int find_hole(int unsigned need);
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!ho_valid[i] || ho_bytes[i] < need) continue;
      if (fit_pol == 0) return i;
      if (best < 0 || ho_bytes[i] < ho_bytes[best]) best = i;
    end
    return best;
  endfunction

  function automatic int find_item(int unsigned id);
    for (int i = 0; i < SLOTS; i++)
      if (it_valid[i] && it_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int free_item_slot();
    for (int i = 0; i < SLOTS; i++)
      if (!it_valid[i]) return i;
    return -1;
  endfunction

  function automatic void compact_store();
    int unsigned pos;
    int k;
    pos = 0;
    k = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!it_valid[i]) continue;
      if (it_off[i] != pos) put(K_MOVE, it_id[i], it_off[i], pos, it_bytes[i], 0);
      it_id[k] = it_id[i];
      it_cor[k] = it_cor[i];
      it_bytes[k] = it_bytes[i];
      it_born[k] = it_born[i];
      it_used[k] = it_used[i];
      it_off[k] = pos & 32'hFFFF;
      it_valid[k] = 1;
      pos += occ_bytes(it_bytes[i]);
      k++;
    end
    for (int i = k; i < SLOTS; i++) it_valid[i] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      ho_valid[i] = 0;
      ho_off[i] = 0;
      ho_bytes[i] = 0;
    end
    if (pos < store_sz) begin
      ho_valid[0] = 1;
      ho_off[0] = pos;
      ho_bytes[0] = store_sz - pos;
    end
    frees = 0;
  endfunction

  function automatic void evict_item(int s);
    int unsigned o, sz;
    int h, lo, hi;
    bit merged;
    o = it_off[s];
    sz = occ_bytes(it_bytes[s]);
    h = -1;
    put(K_EVICTED, it_id[s], 0, 0, 0, 0);
    it_valid[s] = 0;
    if (frees < 255) frees++;
    for (int i = 0; i < SLOTS && h < 0; i++)
      if (!ho_valid[i]) h = i;
    if (h >= 0) begin
      ho_valid[h] = 1;
      ho_off[h] = o;
      ho_bytes[h] = sz;
    end else begin
      for (int i = 0; i < SLOTS && h < 0; i++) begin
        if (ho_off[i] + ho_bytes[i] == o) begin
          ho_bytes[i] += sz;
          h = i;
        end else if (ho_off[i] == o + sz) begin
          ho_off[i] = o;
          ho_bytes[i] += sz;
          h = i;
        end
      end
    end
    merged = h >= 0;
    while (merged) begin
      merged = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (i == h || !ho_valid[i]) continue;
        if (ho_off[i] != ho_off[h] + ho_bytes[h] && ho_off[i] + ho_bytes[i] != ho_off[h])
          continue;
        lo = i < h ? i : h;
        hi = i < h ? h : i;
        ho_off[lo] = ho_off[i] < ho_off[h] ? ho_off[i] : ho_off[h];
        ho_bytes[lo] = ho_bytes[i] + ho_bytes[h];
        ho_valid[hi] = 0;
        ho_off[hi] = 0;
        ho_bytes[hi] = 0;
        h = lo;
        merged = 1;
        break;
      end
    end
    if (compact_n <= 1 || frees >= compact_n) compact_store();
  endfunction

  function automatic int pick_victim();
    int v;
    int unsigned best, age;
    v = -1;
    best = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!it_valid[i]) continue;
      age = stamp - (victim_pol ? it_used[i] : it_born[i]);
      if (v < 0 || age > best) begin
        v = i;
        best = age;
      end
    end
    return v;
  endfunction

  function automatic void allocate(request_t r);
    int unsigned need;
    int s, h, v;
    need = occ_bytes(r.size);
    if (free_item_slot() < 0) begin
      put(K_FAILED, r.id, 0, 0, 0, 0);
      return;
    end
    h = find_hole(need);
    while (h < 0) begin
      v = pick_victim();
      if (v < 0) begin
        put(K_FAILED, r.id, 0, 0, 0, 0);
        return;
      end
      evict_item(v);
      h = find_hole(need);
    end
    s = free_item_slot();
    if (s < 0) begin
      put(K_FAILED, r.id, 0, 0, 0, 0);
      return;
    end
    stamp++;
    it_valid[s] = 1;
    it_id[s] = r.id;
    it_cor[s] = r.cor;
    it_off[s] = ho_off[h];
    it_bytes[s] = r.size;
    it_born[s] = stamp;
    it_used[s] = stamp;
    ho_bytes[h] -= need;
    if (ho_bytes[h] == 0) begin
      ho_valid[h] = 0;
      ho_off[h] = 0;
    end else begin
      ho_off[h] += need;
    end
    put(K_PLACED, r.id, it_off[s], 0, 0, 0);
  endfunction

  function automatic void predict_request(request_t r);
    int n0, s;
    n0 = expected_q.size();
    if (r.req == REQ_ALLOC) begin
      allocate(r);
    end else if (r.req == REQ_TOUCH || r.req == REQ_LOOKUP) begin
      s = find_item(r.id);
      if (s < 0) begin
        put(K_MISS, r.id, 0, 0, 0, 0);
      end else if (r.req == REQ_TOUCH) begin
        stamp++;
        it_used[s] = stamp;
        put(K_TOUCHED, r.id, 0, 0, 0, 0);
      end else begin
        put(K_HIT, r.id, it_off[s], 0, it_bytes[s], it_cor[s]);
      end
    end
    if (expected_q.size() > n0) expected_q[$].last = 1;
  endfunction

  function automatic void reset_model();
    fit_pol = 0;
    victim_pol = 0;
    store_sz = 2048;
    min_part = 32;
    compact_n = 1;
    stamp = 0;
    clear_store();
  endfunction

  function automatic bit idle_now();
    return !(cycles > 4000 && cycles < 9000) && $urandom_range(99) < 23;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[dynamic_partition_allocator] ERROR");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (in_tvalid) predict_request(cur_req);
        if (pending_q.size() > 0 && !idle_now()) begin
          cur_req = pending_q.pop_front();
          in_tvalid <= 1;
          in_tuser <= cur_req.req;
          in_tdata <= {2'b0, cur_req.cor, cur_req.size, cur_req.id};
        end else begin
          in_tvalid <= 0;
        end
      end
      out_tready <= !idle_now();
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind %0d id %0h", out_tuser, out_tdata[30:0]);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_tuser); errors++;
        end
        if (out_tdata[30:0] !== e.id) begin
          $error("out_id: expected %0h actual %0h", e.id, out_tdata[30:0]); errors++;
        end
        if (out_tdata[46:31] !== e.off) begin
          $error("offset: expected %0d actual %0d", e.off, out_tdata[46:31]); errors++;
        end
        if (out_tdata[62:47] !== e.noff) begin
          $error("new_offset: expected %0d actual %0d", e.noff, out_tdata[62:47]); errors++;
        end
        if (out_tdata[78:63] !== e.size) begin
          $error("out_size: expected %0d actual %0d", e.size, out_tdata[78:63]); errors++;
        end
        if (out_tdata[109:79] !== e.cor) begin
          $error("out_correl: expected %0h actual %0h", e.cor, out_tdata[109:79]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, out_tlast); errors++;
        end
      end
    end
  end

  task automatic push_req(logic [1:0] t, logic [30:0] id, logic [15:0] sz, logic [30:0] cor);
    request_t r;
    r.req = t;
    r.id = id;
    r.size = sz;
    r.cor = cor;
    pending_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_FIT:     fit_pol = val[0];
      CFG_VICTIM:  victim_pol = val[0];
      CFG_STORE:   begin store_sz = val; clear_store(); end
      CFG_MINP:    begin min_part = val; clear_store(); end
      CFG_COMPACT: compact_n = val[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic setup(bit fit, bit vic, logic [15:0] st, logic [15:0] mp, logic [7:0] ce);
    write_reg(CFG_FIT, 16'(fit));
    write_reg(CFG_VICTIM, 16'(vic));
    write_reg(CFG_STORE, st);
    write_reg(CFG_MINP, mp);
    write_reg(CFG_COMPACT, 16'(ce));
  endtask

  task automatic random_requests(int n);
    logic [1:0]  t;
    logic [30:0] id;
    logic [15:0] sz;
    int unsigned top;
    top = store_sz / 3 > 2 ? store_sz / 3 : 2;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(19))
        0:       t = 2'd3;
        1, 2, 3: t = REQ_TOUCH;
        4, 5, 6: t = REQ_LOOKUP;
        default: t = REQ_ALLOC;
      endcase
      id = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(11));
      case ($urandom_range(15))
        0:       sz = 16'hFFFF;
        1:       sz = 16'd1;
        default: sz = 16'($urandom_range(top, 1));
      endcase
      push_req(t, id, sz, 31'($urandom));
      if (t == 2'd3) i--;
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1;

    push_req(REQ_ALLOC, 31'd0, 16'd1, 31'd0);
    push_req(REQ_ALLOC, 31'h7FFFFFFF, 16'hFFFF, 31'h12345);
    push_req(REQ_ALLOC, 31'd5, 16'd100, 31'h7FFFFFFF);
    push_req(REQ_ALLOC, 31'd5, 16'd2, 31'h2AAAAAAA);
    push_req(REQ_TOUCH, 31'd5, 16'd0, 31'd0);
    push_req(REQ_LOOKUP, 31'd5, 16'd0, 31'd0);
    push_req(REQ_TOUCH, 31'd99, 16'd0, 31'd0);
    push_req(REQ_LOOKUP, 31'h7FFFFFFF, 16'd0, 31'd0);
    push_req(2'd3, 31'd5, 16'd7, 31'd1);
    for (int i = 10; i < 17; i++)
      push_req(REQ_ALLOC, 31'(i), 16'd200, 31'(32'h55555555 ^ i));
    push_req(REQ_TOUCH, 31'd10, 16'd0, 31'd0);
    push_req(REQ_ALLOC, 31'd30, 16'd1000, 31'd3);
    push_req(REQ_LOOKUP, 31'd30, 16'd0, 31'd0);
    push_req(REQ_LOOKUP, 31'd12, 16'd0, 31'd0);
    wait_drained();

    setup(1, 1, 16'd512, 16'd16, 8'd3);
    random_requests(30);
    wait_drained();
    setup(0, 1, 16'd300, 16'd32, 8'd2);
    random_requests(25);
    wait_drained();
    setup(1, 0, 16'hFFFF, 16'd1, 8'd0);
    random_requests(25);
    wait_drained();
    setup(0, 0, 16'd1, 16'hFFFF, 8'd255);
    random_requests(10);
    wait_drained();
    setup(1, 1, 16'd2048, 16'd64, 8'd1);
    random_requests(10);
    wait_drained();

    if (errors == 0) begin
      $display("[dynamic_partition_allocator] OK");
    end else begin
      $display("[dynamic_partition_allocator] ERROR");
    end
    $finish;
  end

endmodule
